### sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

### sv/cach_pkg.sv
// types, codes and helpers of the adaptive channel hopper
`timescale 1ns / 1ps
`default_nettype none

package cach_pkg;

    localparam int CHAN_W   = 7;
    localparam int LOSS_W   = 8;
    localparam int PCOUNT_W = 3;
    localparam int PEER_W   = 2;
    localparam int POS_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_EVENT = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    localparam logic [1:0] EV_TX_OK   = 2'd0;
    localparam logic [1:0] EV_TX_FAIL = 2'd1;
    localparam logic [1:0] EV_RX      = 2'd2;
    localparam logic [1:0] EV_OTHER   = 2'd3;

    localparam logic [1:0] KIND_POLL   = 2'd0;
    localparam logic [1:0] KIND_TUNE   = 2'd1;
    localparam logic [1:0] KIND_NOTICE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT     = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_EVAL,
        ST_TICK_BYTE,
        ST_TICK_SWAP,
        ST_LOAD,
        ST_EV_START,
        ST_EV_NOTE,
        ST_EV_ADV,
        ST_EV_TUNE_RD,
        ST_EV_TUNE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       in_ready;
        logic       cnt_eval;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_slot;
        logic       ev_mark;
        logic       peer_adv;
        logic       swap;
        logic       load_wr;
        logic       emit;
        logic [1:0] emit_kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       in_acc;
        logic [1:0] in_func;
        logic [1:0] item_event;
        logic       out_free;
        logic       idx_last;
        logic       hit;
        logic       wrap;
    } t_stat;

    // next peer index, peer count clamped to 1..4
    function automatic logic [PEER_W-1:0] peer_next(logic [PEER_W-1:0] peer,
                                                     logic [PCOUNT_W-1:0] pcount);
        logic [PCOUNT_W-1:0] eff;
        logic [PCOUNT_W-1:0] r;
        eff = (pcount == 3'd0) ? 3'd1 : ((pcount > 3'd4) ? 3'd4 : pcount);
        r   = {1'b0, peer} + 3'd1;
        for (int k = 0; k < 4; k++) begin
            if (r >= eff) begin
                r = r - eff;
            end
        end
        return r[PEER_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/cach_if.sv
// handshake channels: input items, result items, configuration writes
`timescale 1ns / 1ps
`default_nettype none

interface cach_in_if;
    import cach_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [1:0]        event_code;
    logic [POS_W-1:0]  load_position;
    logic [CHAN_W-1:0] load_channel;
    modport source (output valid, func, event_code, load_position, load_channel,
                    input ready);
    modport sink (input valid, func, event_code, load_position, load_channel,
                  output ready);
endinterface

interface cach_out_if;
    import cach_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic [PCOUNT_W-1:0] peer_prefix;
    logic [1:0]          slot;
    logic [CHAN_W-1:0]   channel;
    logic                table_changed;
    logic                last;
    modport source (output valid, kind, peer_prefix, slot, channel, table_changed, last,
                    input ready);
    modport sink (input valid, kind, peer_prefix, slot, channel, table_changed, last,
                  output ready);
endinterface

interface cach_cfg_if;
    import cach_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/cach_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module cach_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/cach_dp.sv
// datapath: tables, loss counters, slot and peer state, result register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cach_dp #(
    parameter int USED_SLOTS  = 3,
    parameter int SPARE_SLOTS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  cach_pkg::t_cmd i_cmd,
    output cach_pkg::t_stat o_stat,
    cach_in_if.sink       i_item,
    cach_out_if.source    o_result,
    cach_cfg_if.sink      i_cfg
);
    import cach_pkg::*;

    localparam int UW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int SW = $clog2(SPARE_SLOTS);
    localparam int KW = ((SW > POS_W) ? SW : POS_W) + 1;

    // configuration
    logic [LOSS_W-1:0]   r_thresh;
    logic [PCOUNT_W-1:0] r_pcount;

    // latched item
    logic [1:0]        r_event;
    logic [POS_W-1:0]  r_pos;
    logic [CHAN_W-1:0] r_lchan;

    // hopping state
    logic [UW-1:0]     r_slot, n_slot;
    logic [PEER_W-1:0] r_peer, n_peer;
    logic              r_armed;
    logic              r_hit;
    logic [LOSS_W-1:0] r_loss [USED_SLOTS];
    logic [UW-1:0]     r_idx, n_idx;
    logic [CHAN_W-1:0] r_old;
    logic [SW-1:0]     r_head, n_head;

    // result register
    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [PCOUNT_W-1:0] r_out_prefix;
    logic [1:0]        r_out_slot;
    logic [CHAN_W-1:0] r_out_chan;
    logic              r_out_changed;
    logic              r_out_last;

    logic              in_acc;
    logic              out_free;
    logic              idx_last;
    logic [LOSS_W-1:0] loss_inc;
    logic              hit_now;
    logic              wrap;

    logic              pos_used;
    logic [POS_W-1:0]  spare_k;
    logic              spare_ok;
    logic [KW-1:0]     spare_sum;
    logic [SW-1:0]     spare_waddr;

    logic              used_we;
    logic [UW-1:0]     used_waddr;
    logic [CHAN_W-1:0] used_wdata;
    logic [UW-1:0]     used_raddr;
    logic [CHAN_W-1:0] used_rdata;
    logic              spare_we;
    logic [SW-1:0]     spare_wa;
    logic [CHAN_W-1:0] spare_wdata;
    logic [CHAN_W-1:0] spare_rdata;

    logic              out_last;
    logic [UW-1:0]     out_slot;

    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_result.ready;
    assign idx_last = (r_idx == UW'(USED_SLOTS - 1));
    assign loss_inc = r_loss[r_slot] + 8'd1;
    assign hit_now  = (loss_inc == r_thresh);
    assign n_peer   = peer_next(r_peer, r_pcount);
    assign wrap     = (n_peer == '0);
    assign n_slot   = (r_slot == UW'(USED_SLOTS - 1)) ? '0 : r_slot + 1'b1;
    assign n_head   = (r_head == SW'(SPARE_SLOTS - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end
    end

    // spare position is relative to the fifo head
    assign pos_used  = ({1'b0, r_pos} < 5'(USED_SLOTS));
    assign spare_k   = r_pos - POS_W'(USED_SLOTS);
    assign spare_ok  = !pos_used && (KW'(spare_k) < KW'(SPARE_SLOTS));
    always_comb begin
        spare_sum = KW'(r_head) + KW'(spare_k);
        if (spare_sum >= KW'(SPARE_SLOTS)) begin
            spare_sum = spare_sum - KW'(SPARE_SLOTS);
        end
    end
    assign spare_waddr = spare_sum[SW-1:0];

    assign used_we     = (i_cmd.load_wr && pos_used) || i_cmd.swap;
    assign used_waddr  = i_cmd.swap ? r_slot : r_pos[UW-1:0];
    assign used_wdata  = i_cmd.swap ? spare_rdata : r_lchan;
    assign used_raddr  = i_cmd.rd_slot ? r_slot : n_idx;
    assign spare_we    = (i_cmd.load_wr && spare_ok) || i_cmd.swap;
    assign spare_wa    = i_cmd.swap ? r_head : spare_waddr;
    assign spare_wdata = i_cmd.swap ? r_old : r_lchan;

    cach_ram #(.WIDTH(CHAN_W), .DEPTH(USED_SLOTS)) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (used_we),
        .i_waddr (used_waddr),
        .i_wdata (used_wdata),
        .i_raddr (used_raddr),
        .o_rdata (used_rdata)
    );

    cach_ram #(.WIDTH(CHAN_W), .DEPTH(SPARE_SLOTS)) u_spare_ram (
        .i_clk   (i_clk),
        .i_we    (spare_we),
        .i_waddr (spare_wa),
        .i_wdata (spare_wdata),
        .i_raddr (r_head),
        .o_rdata (spare_rdata)
    );

    // configuration writes
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 8'd4;
            r_pcount <= 3'd2;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LOSS_THRESHOLD: r_thresh <= i_cfg.data;
                CFG_PEER_COUNT:     r_pcount <= i_cfg.data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = i_cmd.in_ready;
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_event <= i_item.event_code;
            r_pos   <= i_item.load_position;
            r_lchan <= i_item.load_channel;
        end
    end

    // slot, peer, counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_peer  <= '0;
            r_armed <= 1'b0;
            r_hit   <= 1'b0;
            r_head  <= '0;
            r_idx   <= '0;
            for (int k = 0; k < USED_SLOTS; k++) begin
                r_loss[k] <= '0;
            end
        end else begin
            r_idx <= n_idx;
            if (i_cmd.cnt_eval) begin
                r_hit <= r_armed && hit_now;
                if (r_armed) begin
                    if (hit_now) begin
                        r_armed <= 1'b0;
                        for (int k = 0; k < USED_SLOTS; k++) begin
                            r_loss[k] <= '0;
                        end
                    end else begin
                        r_loss[r_slot] <= loss_inc;
                    end
                end
            end
            if (i_cmd.ev_mark) begin
                r_loss[r_slot] <= '0;
                r_armed        <= 1'b1;
            end
            if (i_cmd.peer_adv) begin
                r_peer <= n_peer;
                if (wrap) begin
                    r_slot <= n_slot;
                end
            end
            if (i_cmd.swap) begin
                r_head <= n_head;
            end
        end
    end

    // channel being replaced, caught as its poll byte goes out
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && (i_cmd.emit_kind == KIND_POLL) && (r_idx == r_slot)) begin
            r_old <= used_rdata;
        end
    end

    always_comb begin
        out_last = 1'b1;
        out_slot = r_slot;
        case (i_cmd.emit_kind)
            KIND_POLL: begin
                out_last = idx_last;
                out_slot = r_idx;
            end
            KIND_NOTICE: out_last = !wrap;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind    <= i_cmd.emit_kind;
            r_out_prefix  <= {1'b0, r_peer} + 3'd1;
            r_out_slot    <= 2'(out_slot);
            r_out_chan    <= used_rdata;
            r_out_changed <= (i_cmd.emit_kind == KIND_POLL) && idx_last && r_hit;
            r_out_last    <= out_last;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out_kind;
    assign o_result.peer_prefix   = r_out_prefix;
    assign o_result.slot          = r_out_slot;
    assign o_result.channel       = r_out_chan;
    assign o_result.table_changed = r_out_changed;
    assign o_result.last          = r_out_last;

    assign o_stat.in_acc     = in_acc;
    assign o_stat.in_func    = i_item.func;
    assign o_stat.item_event = r_event;
    assign o_stat.out_free   = out_free;
    assign o_stat.idx_last   = idx_last;
    assign o_stat.hit        = r_hit;
    assign o_stat.wrap       = wrap;

    `ASSERT_NEVER(a_slot_range, i_clk, i_rst_n, int'(r_slot) >= USED_SLOTS,
        "slot index out of table range")
    `ASSERT_CLK(a_disarm_on_hit, i_clk, i_rst_n,
        (i_cmd.cnt_eval && r_armed && hit_now) |=> (!r_armed && r_hit),
        "threshold hit did not disarm hopping")

endmodule

`default_nettype wire

### sv/cach_ctrl.sv
// controller state machine sequencing ticks, events and loads
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cach_ctrl (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  cach_pkg::t_stat i_stat,
    output cach_pkg::t_cmd  o_cmd
);
    import cach_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.in_acc) begin
                    unique case (i_stat.in_func)
                        FUNC_TICK:  n_state = ST_TICK_EVAL;
                        FUNC_EVENT: n_state = ST_EV_START;
                        FUNC_LOAD:  n_state = ST_LOAD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK_EVAL: n_state = ST_TICK_BYTE;
            ST_TICK_BYTE: begin
                if (i_stat.out_free && i_stat.idx_last) begin
                    n_state = i_stat.hit ? ST_TICK_SWAP : ST_IDLE;
                end
            end
            ST_TICK_SWAP: n_state = ST_IDLE;
            ST_LOAD:      n_state = ST_IDLE;
            ST_EV_START: begin
                unique case (i_stat.item_event)
                    EV_TX_OK: n_state = ST_IDLE;
                    EV_RX:    n_state = ST_EV_NOTE;
                    default:  n_state = ST_EV_ADV;
                endcase
            end
            ST_EV_NOTE: begin
                if (i_stat.out_free) begin
                    n_state = ST_EV_ADV;
                end
            end
            ST_EV_ADV:     n_state = i_stat.wrap ? ST_EV_TUNE_RD : ST_IDLE;
            ST_EV_TUNE_RD: n_state = ST_EV_TUNE;
            ST_EV_TUNE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.emit_kind = KIND_POLL;
        unique case (r_state)
            ST_IDLE:      o_cmd.in_ready = 1'b1;
            ST_TICK_EVAL: begin
                o_cmd.cnt_eval = 1'b1;
                o_cmd.idx_clr  = 1'b1;
            end
            ST_TICK_BYTE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.idx_inc = !i_stat.idx_last;
                end
            end
            ST_TICK_SWAP: o_cmd.swap    = 1'b1;
            ST_LOAD:      o_cmd.load_wr = 1'b1;
            ST_EV_START: begin
                o_cmd.rd_slot = 1'b1;
                o_cmd.ev_mark = (i_stat.item_event == EV_RX);
            end
            ST_EV_NOTE: begin
                o_cmd.rd_slot   = 1'b1;
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_kind = KIND_NOTICE;
            end
            ST_EV_ADV:     o_cmd.peer_adv = 1'b1;
            ST_EV_TUNE_RD: o_cmd.rd_slot  = 1'b1;
            ST_EV_TUNE: begin
                o_cmd.rd_slot   = 1'b1;
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_kind = KIND_TUNE;
            end
            default: ;
        endcase
    end

    `ASSERT_NEVER(a_emit_when_full, i_clk, i_rst_n, o_cmd.emit && !i_stat.out_free,
        "result loaded while previous beat still waits")
    `ASSERT_CLK(a_swap_after_hit, i_clk, i_rst_n,
        (r_state == ST_TICK_SWAP) |-> ($past(r_state) == ST_TICK_BYTE && $past(i_stat.hit)),
        "channel swap without a threshold hit")

endmodule

`default_nettype wire

### sv/central_adaptive_channel_hopper.sv
// top level of the central adaptive channel hopper
`timescale 1ns / 1ps
`default_nettype none

// Central side of a polled radio link with adaptive hopping. The block keeps a
// table of used channels, a fifo of spare channels, a loss counter per slot, a
// hop-armed flag and the current slot and peer. Input beats on i_item carry a
// func code: a poll tick sends one poll byte per used slot (each tagged with
// the peer prefix, the last one flagging a channel swap); a radio event may
// give a data-received notice and, when the peer index wraps, a tune beat for
// the next slot; a load writes one table entry (positions below USED_SLOTS go
// to the used table, those below USED_SLOTS + SPARE_SLOTS to the spare fifo
// counted from its head, higher ones are dropped). The last field marks the
// final result beat of each input. Timing: one item is handled at a time by
// the sequencer; a result beat waits in an output register and holds the
// sequencer only while the sink holds ready low. Configuration writes on i_cfg
// are taken at any time but must only change registers while the block is
// idle. Channel tables have no reset: every entry must be loaded before it is
// used.

module central_adaptive_channel_hopper #(
    parameter int USED_SLOTS  = 3,
    parameter int SPARE_SLOTS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cach_in_if.sink    i_item,
    cach_out_if.source o_result,
    cach_cfg_if.sink   i_cfg
);
    import cach_pkg::*;

    // command and status between sequencer and datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    cach_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // tables, counters and the result register live in the datapath
    cach_dp #(
        .USED_SLOTS  (USED_SLOTS),
        .SPARE_SLOTS (SPARE_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

`default_nettype wire

### test/central_adaptive_channel_hopper_checker.sv
// checker for the channel hopper: tracks hop state, predicts result beats and compares them
`timescale 1ns / 1ps

module central_adaptive_channel_hopper_checker #(
    parameter int USED_SLOTS  = 3,
    parameter int SPARE_SLOTS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cach_in_if   i_item,
    cach_out_if  i_result,
    cach_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import cach_pkg::*;

    typedef struct packed {
        logic [1:0]          kind;
        logic [PCOUNT_W-1:0] peer_prefix;
        logic [1:0]          slot;
        logic [CHAN_W-1:0]   channel;
        logic                table_changed;
        logic                last;
    } t_hop_beat;

    // predicted hopper state
    logic [CHAN_W-1:0]   used_ch [USED_SLOTS];
    logic [CHAN_W-1:0]   spare_ch [SPARE_SLOTS];
    logic [LOSS_W-1:0]   miss_cnt [USED_SLOTS];
    logic                hop_armed;
    int                  slot_idx;
    logic [PEER_W-1:0]   peer_idx;
    logic [LOSS_W-1:0]   loss_limit;
    logic [PCOUNT_W-1:0] peer_total;

    t_hop_beat beats_due[$];
    int        beat_no;

    task automatic report(input string msg);
        if (o_errors < 40) begin
            $display("%0t ns: %s", $time, msg);
        end
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("beat %0d: %s is %0d, expected %0d", beat_no, name, got, want));
        end
    endtask

    function automatic t_hop_beat make_beat(input logic [1:0] kind, input int slot,
                                            input logic [CHAN_W-1:0] chan,
                                            input logic changed, input logic fin);
        t_hop_beat b;
        b.kind          = kind;
        b.peer_prefix   = PCOUNT_W'(peer_idx) + 1'b1;
        b.slot          = 2'(slot);
        b.channel       = chan;
        b.table_changed = changed;
        b.last          = fin;
        return b;
    endfunction

    // poll bytes carry the table as it stood before any swap made by this tick
    task automatic apply_tick();
        logic [CHAN_W-1:0] snap [USED_SLOTS];
        logic [CHAN_W-1:0] retired;
        logic              swapped;
        snap    = used_ch;
        swapped = 1'b0;
        if (hop_armed) begin
            miss_cnt[slot_idx] = miss_cnt[slot_idx] + 1'b1;
            if (miss_cnt[slot_idx] == loss_limit) begin
                retired = used_ch[slot_idx];
                for (int k = 0; k < USED_SLOTS; k++) begin
                    miss_cnt[k] = '0;
                end
                hop_armed          = 1'b0;
                used_ch[slot_idx]  = spare_ch[0];
                for (int k = 0; k < SPARE_SLOTS - 1; k++) begin
                    spare_ch[k] = spare_ch[k + 1];
                end
                spare_ch[SPARE_SLOTS - 1] = retired;
                swapped = 1'b1;
            end
        end
        for (int k = 0; k < USED_SLOTS; k++) begin
            beats_due.push_back(make_beat(KIND_POLL, k, snap[k],
                                          (k == USED_SLOTS - 1) && swapped,
                                          k == USED_SLOTS - 1));
        end
    endtask

    task automatic apply_event(input logic [1:0] code);
        int  live;
        int  nxt;
        logic wrapped;
        if (code != EV_TX_OK) begin
            // peer count 0 behaves as 1, anything above 4 as 4
            live    = (peer_total == 0) ? 1 : ((peer_total > 4) ? 4 : int'(peer_total));
            nxt     = (int'(peer_idx) + 1) % live;
            wrapped = (nxt == 0);
            if (code == EV_RX) begin
                miss_cnt[slot_idx] = '0;
                hop_armed          = 1'b1;
                beats_due.push_back(make_beat(KIND_NOTICE, slot_idx, used_ch[slot_idx],
                                              1'b0, !wrapped));
            end
            peer_idx = PEER_W'(nxt);
            if (wrapped) begin
                slot_idx = (slot_idx + 1) % USED_SLOTS;
                beats_due.push_back(make_beat(KIND_TUNE, slot_idx, used_ch[slot_idx],
                                              1'b0, 1'b1));
            end
        end
    endtask

    task automatic apply_load(input logic [POS_W-1:0] pos, input logic [CHAN_W-1:0] chan);
        if (pos < USED_SLOTS) begin
            used_ch[pos] = chan;
        end else if (pos - USED_SLOTS < SPARE_SLOTS) begin
            spare_ch[pos - USED_SLOTS] = chan;
        end
    endtask

    task automatic check_beat();
        t_hop_beat want;
        beat_no++;
        if (beats_due.size() == 0) begin
            report($sformatf("beat %0d: kind %0d slot %0d channel %0d with nothing expected",
                             beat_no, i_result.kind, i_result.slot, i_result.channel));
        end else begin
            want = beats_due.pop_front();
            check_field("kind", 8'(i_result.kind), 8'(want.kind));
            check_field("peer_prefix", 8'(i_result.peer_prefix), 8'(want.peer_prefix));
            check_field("slot", 8'(i_result.slot), 8'(want.slot));
            check_field("channel", 8'(i_result.channel), 8'(want.channel));
            check_field("table_changed", 8'(i_result.table_changed), 8'(want.table_changed));
            check_field("last", 8'(i_result.last), 8'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < USED_SLOTS; k++) begin
                used_ch[k]  = '0;
                miss_cnt[k] = '0;
            end
            for (int k = 0; k < SPARE_SLOTS; k++) begin
                spare_ch[k] = '0;
            end
            hop_armed  = 1'b0;
            slot_idx   = 0;
            peer_idx   = '0;
            loss_limit = 8'd4;
            peer_total = 3'd2;
            beats_due.delete();
            beat_no    = 0;
        end else begin
            // results of an item never leave in the beat that accepts it
            if (i_result.valid && i_result.ready) begin
                check_beat();
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_LOSS_THRESHOLD: loss_limit = i_cfg.data;
                    CFG_PEER_COUNT:     peer_total = i_cfg.data[PCOUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                case (i_item.func)
                    FUNC_TICK:  apply_tick();
                    FUNC_EVENT: apply_event(i_item.event_code);
                    FUNC_LOAD:  apply_load(i_item.load_position, i_item.load_channel);
                    default: ;
                endcase
            end
        end
        o_pending = beats_due.size();
    end

endmodule

### test/central_adaptive_channel_hopper_tb.sv
// testbench top for the channel hopper: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module central_adaptive_channel_hopper_tb;
    import cach_pkg::*;

    localparam int USED_SLOTS  = 3;
    localparam int SPARE_SLOTS = 8;

    // func value with no meaning, and a register index with no register behind it
    localparam logic [1:0]           FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG  = 2'd3;

    // idle margin after the last beat: covers the end of a tick and an item with no result
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 30;
    localparam int HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   failures;
    int   pending;

    // flow-control state of the driver processes
    logic tx_burst = 1'b0;
    logic rx_hold = 1'b0;
    logic rx_hold_req = 1'b0;

    cach_in_if  item_bus ();
    cach_out_if result_bus ();
    cach_cfg_if cfg_bus ();

    central_adaptive_channel_hopper #(
        .USED_SLOTS  (USED_SLOTS),
        .SPARE_SLOTS (SPARE_SLOTS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    central_adaptive_channel_hopper_checker #(
        .USED_SLOTS  (USED_SLOTS),
        .SPARE_SLOTS (SPARE_SLOTS)
    ) checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_bus),
        .i_result  (result_bus),
        .i_cfg     (cfg_bus),
        .o_errors  (failures),
        .o_pending (pending)
    );

    always #10 i_clk = ~i_clk;

    // offer one item after a random gap and hold it until the block takes the beat;
    // valid stays high on return so back-to-back items need no extra edge
    task automatic send_item(input logic [1:0] func, input logic [1:0] code,
                             input logic [POS_W-1:0] pos, input logic [CHAN_W-1:0] chan);
        int gap;
        if ($urandom_range(0, 15) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.func          <= func;
        item_bus.event_code    <= code;
        item_bus.load_position <= pos;
        item_bus.load_channel  <= chan;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
    endtask

    // register write; valid is left high so several writes can run back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // stop offering, wait for every predicted beat, then let the sequencer go idle
    task automatic drain();
        int guard;
        item_bus.valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending != 0 && guard < 20000);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result sink: random stall per beat, bursts with none, and one long hold-off
    initial begin
        int   gap;
        logic burst;
        burst = 1'b0;
        result_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                burst = !burst;
            end
            gap = burst ? 0 : $urandom_range(0, 19);
            if (gap != 0 || rx_hold) begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_bus.valid) @(posedge i_clk);
        end
    end

    // long hold-off on the result side while items keep coming, so the block backs up
    initial begin
        wait (rx_hold_req);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // overall limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("central_adaptive_channel_hopper: mismatch");
        $finish;
    end

    initial begin
        int                    counted;
        int                    pick;
        logic [1:0]            func;
        logic [1:0]            code;
        logic [POS_W-1:0]      pos;
        logic [CHAN_W-1:0]     chan;
        logic [LOSS_W-1:0]     limit_val;
        logic [PCOUNT_W-1:0]   peers_val;

        i_rst_n                <= 1'b0;
        item_bus.valid         <= 1'b0;
        item_bus.func          <= FUNC_TICK;
        item_bus.event_code    <= EV_TX_OK;
        item_bus.load_position <= '0;
        item_bus.load_channel  <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.index          <= CFG_LOSS_THRESHOLD;
        cfg_bus.data           <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings: threshold 4, two peers
        // fill every used and spare entry first, so nothing unwritten is ever read
        for (int k = 0; k < USED_SLOTS + SPARE_SLOTS; k++) begin
            if (k == 0) begin
                chan = 7'd0;
            end else if (k == 1) begin
                chan = 7'd127;
            end else begin
                chan = 7'($urandom_range(0, 127));
            end
            send_item(FUNC_LOAD, 2'(k), POS_W'(k), chan);
        end
        // loads past both tables and the unused func are dropped without a result
        send_item(FUNC_LOAD, EV_OTHER, 4'd15, 7'd127);
        send_item(FUNC_LOAD, EV_RX, 4'd11, 7'd0);
        send_item(FUNC_UNUSED, EV_OTHER, 4'd15, 7'd127);
        // tick while hopping is still disarmed: plain table dump
        send_item(FUNC_TICK, EV_TX_OK, 4'd0, 7'd0);
        // tx success is silent, tx failed moves the peer, the wrap retunes to slot 1
        send_item(FUNC_EVENT, EV_TX_OK, 4'd0, 7'd0);
        send_item(FUNC_EVENT, EV_TX_FAIL, 4'd0, 7'd0);
        send_item(FUNC_EVENT, EV_OTHER, 4'd0, 7'd0);
        // packet received arms hopping, four missed ticks reach the threshold and swap
        send_item(FUNC_EVENT, EV_RX, 4'd0, 7'd0);
        repeat (4) send_item(FUNC_TICK, EV_TX_OK, 4'd0, 7'd0);
        // table after the swap, then notice followed by a tune on the peer wrap
        send_item(FUNC_TICK, EV_TX_OK, 4'd0, 7'd0);
        send_item(FUNC_EVENT, EV_RX, 4'd0, 7'd0);

        // random phases, each with its own register settings
        for (int ph = 1; ph <= 6; ph++) begin
            drain();
            case (ph)
                1: begin limit_val = 8'd1;   peers_val = 3'd1; end
                2: begin limit_val = 8'd255; peers_val = 3'd4; end
                3: begin limit_val = 8'd0;   peers_val = 3'd0; end
                4: begin limit_val = 8'd2;   peers_val = 3'd7; end
                5: begin limit_val = 8'd3;   peers_val = 3'd5; end
                default: begin
                    limit_val = 8'($urandom_range(1, 6));
                    peers_val = 3'($urandom_range(0, 7));
                end
            endcase
            write_reg(CFG_LOSS_THRESHOLD, limit_val);
            // upper data bits carry no meaning for the peer count
            write_reg(CFG_PEER_COUNT, {5'($urandom), peers_val});
            if (ph == 3) begin
                write_reg(CFG_NO_REG, 8'($urandom));
            end
            cfg_bus.valid <= 1'b0;

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (ph == 2 && counted == 5) begin
                    rx_hold_req = 1'b1;
                end
                // mostly ticks and events so receptions arm hopping and ticks drive swaps
                pick = $urandom_range(0, 99);
                code = 2'($urandom_range(0, 3));
                pos  = 4'($urandom_range(0, 15));
                chan = 7'($urandom_range(0, 127));
                if (pick < 40) begin
                    func = FUNC_TICK;
                end else if (pick < 78) begin
                    func = FUNC_EVENT;
                    if ($urandom_range(0, 1) == 1) begin
                        code = EV_RX;
                    end
                end else if (pick < 95) begin
                    func = FUNC_LOAD;
                    if ($urandom_range(0, 4) != 0) begin
                        pos = 4'($urandom_range(0, USED_SLOTS + SPARE_SLOTS - 1));
                    end
                end else begin
                    func = FUNC_UNUSED;
                end
                send_item(func, code, pos, chan);
                if (func != FUNC_UNUSED &&
                    !(func == FUNC_LOAD && pos >= USED_SLOTS + SPARE_SLOTS)) begin
                    counted++;
                end
            end
        end

        drain();
        if (failures == 0 && pending == 0) begin
            $display("central_adaptive_channel_hopper: match");
        end else begin
            $display("central_adaptive_channel_hopper: mismatch");
        end
        $finish;
    end

endmodule
